[rtl/assert_macros.svh]
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/htlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package htlp_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 4;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] res_t;
  typedef logic [1:0] slot_st_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_SEARCH = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  localparam slot_st_t ST_EMPTY   = 2'd0;
  localparam slot_st_t ST_USED    = 2'd1;
  localparam slot_st_t ST_DELETED = 2'd2;

  localparam res_t RES_DONE    = 2'd0;
  localparam res_t RES_FOUND   = 2'd1;
  localparam res_t RES_MISSING = 2'd2;
  localparam res_t RES_FULL    = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    slot_st_t         st;
  } entry_t;

endpackage

`default_nettype wire

[rtl/hash_table_linear_probe.sv]
// Open-addressing hash table with linear probing and deleted markers, held
// in one synchronous memory of SLOTS entries (key plus status), with one
// write port and one read port. After reset the block clears every slot
// with busy high. A beat is taken when start is high and busy is low. Each
// operation probes one slot per cycle, set by the single memory read port,
// in the issue state and then the check state, 1 to SLOTS probes. Unless
// SLOTS is a power of two, the key is first reduced mod SLOTS, 8 bits a cycle.
// An unused command answers without going busy. The result appears as a
// single-cycle out_valid beat in the first cycle with busy low after the
// item; the receiver cannot stall it, so it must take every beat as shown.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hash_table_linear_probe
  import htlp_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_command,
  input  wire logic [KEY_W-1:0] in_key_value,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [IDX_W-1:0]      out_slot_index
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [AW-1:0] LAST_POS = AW'(SLOTS - 1);
  localparam logic [AW:0] SLOTS_EXT = (AW + 1)'(SLOTS);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  entry_t tbl_mem [SLOTS];
  entry_t rdata_r;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    chk_r, chk_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       dig_r, dig_nxt;
  logic [AW:0]      rem_r, rem_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] ksh_r, ksh_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_status_r, out_status_nxt;
  logic [AW-1:0]    out_pos_r, out_pos_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  entry_t           mem_wd;
  logic [AW-1:0]    mem_ra;
  logic [AW-1:0]    pos_inc;
  logic [AW-1:0]    chk_inc;
  logic [AW+IDX_W-1:0] out_pos_ext;

  assign pos_inc = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
  assign chk_inc = (chk_r == LAST_POS) ? '0 : chk_r + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= tbl_mem[mem_ra];
  end

  always_comb begin
    logic [AW:0] r;
    logic        hit;
    logic        last;
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    chk_nxt        = chk_r;
    cnt_nxt        = cnt_r;
    dig_nxt        = dig_r;
    rem_nxt        = rem_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    ksh_nxt        = ksh_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    mem_we         = 1'b0;
    mem_wa         = chk_r;
    mem_wd.key     = key_r;
    mem_wd.st      = ST_USED;
    mem_ra         = pos_r;
    r              = rem_r;
    hit            = 1'b0;
    last           = (cnt_r == LAST_POS);
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r;
        mem_wd.st = ST_EMPTY;
        pos_nxt   = pos_inc;
        if (pos_r == LAST_POS) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          key_nxt = in_key_value;
          ksh_nxt = in_key_value;
          rem_nxt = '0;
          dig_nxt = '0;
          if (!(in_command inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE})) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_MISSING;
            out_pos_nxt    = '0;
          end else if (IS_POW2) begin
            pos_nxt   = in_key_value[AW-1:0];
            state_nxt = S_ISSUE;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        for (int i = 0; i < 8; i++) begin
          r = {r[AW-1:0], ksh_r[KEY_W-1-i]};
          if (r >= SLOTS_EXT) begin
            r = r - SLOTS_EXT;
          end
        end
        rem_nxt = r;
        ksh_nxt = {ksh_r[KEY_W-9:0], 8'd0};
        dig_nxt = dig_r + 1'b1;
        if (dig_r == 2'd3) begin
          pos_nxt   = r[AW-1:0];
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        chk_nxt   = pos_r;
        pos_nxt   = pos_inc;
        cnt_nxt   = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        chk_nxt = chk_inc;
        pos_nxt = pos_inc;
        cnt_nxt = cnt_r + 1'b1;
        if (cmd_r == CMD_INSERT) begin
          if (rdata_r.st != ST_USED) begin
            mem_we         = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_DONE;
            out_pos_nxt    = chk_r;
            state_nxt      = S_IDLE;
          end else if (last) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_FULL;
            out_pos_nxt    = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          hit = (rdata_r.st == ST_USED) && (rdata_r.key == key_r);
          if (hit) begin
            mem_we         = (cmd_r == CMD_DELETE);
            mem_wd.st      = ST_DELETED;
            out_valid_nxt  = 1'b1;
            out_status_nxt = (cmd_r == CMD_DELETE) ? RES_DONE : RES_FOUND;
            out_pos_nxt    = chk_r;
            state_nxt      = S_IDLE;
          end else if (rdata_r.st == ST_EMPTY || last) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = RES_MISSING;
            out_pos_nxt    = '0;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r        <= chk_nxt;
    cnt_r        <= cnt_nxt;
    dig_r        <= dig_nxt;
    rem_r        <= rem_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    ksh_r        <= ksh_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  assign out_pos_ext    = {{IDX_W{1'b0}}, out_pos_r};
  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_pos_ext[IDX_W-1:0];

  `ASSERT_ALWAYS(a_beat_when_idle, !out_valid_r || state_r == S_IDLE, "result beat while busy")
  `ASSERT_NEXT(a_accept_moves, start && !busy, busy || out_valid_r, "accepted item stalled")
  `ASSERT_ALWAYS(a_no_beat_in_clear, state_r != S_CLR || !out_valid_r, "result during clear")

endmodule

`default_nettype wire

[sim/hash_table_linear_probe_tb.sv]
`timescale 1ns / 1ps

module hash_table_linear_probe_tb;
  import htlp_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 450;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } table_op_t;

  typedef struct packed {
    res_t             status;
    logic [IDX_W-1:0] slot;
  } op_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  cmd_t             in_command = CMD_INSERT;
  logic [KEY_W-1:0] in_key_value = '0;
  logic             busy;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_slot_index;

  // predicted table contents
  logic [KEY_W-1:0] slot_key_m [NUM_SLOTS];
  slot_st_t         slot_st_m  [NUM_SLOTS];

  table_op_t        pending_ops[$];
  op_result_t       pending_results[$];
  logic [KEY_W-1:0] live_keys[$];
  op_result_t       oldest;

  int total_ops = 0;
  int real_ops = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int idle_left = 0;
  bit no_idle = 1'b0;

  hash_table_linear_probe #(.SLOTS(NUM_SLOTS)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key_value   (in_key_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Applies one operation to the predicted table and returns its result.
  function automatic op_result_t apply_op(cmd_t cmd, logic [KEY_W-1:0] key);
    op_result_t  r;
    int unsigned pos;
    int unsigned n;
    bit          hit;
    r.status = RES_MISSING;
    r.slot = '0;
    pos = key % NUM_SLOTS;
    n = 0;
    hit = 1'b0;
    if (cmd == CMD_INSERT) begin
      while (n < NUM_SLOTS && !hit) begin
        if (slot_st_m[pos] != ST_USED) hit = 1'b1;
        else begin
          pos = (pos + 1) % NUM_SLOTS;
          n++;
        end
      end
      if (hit) begin
        slot_key_m[pos] = key;
        slot_st_m[pos] = ST_USED;
        r.status = RES_DONE;
        r.slot = pos[IDX_W-1:0];
      end else begin
        r.status = RES_FULL;
      end
    end else if (cmd == CMD_SEARCH || cmd == CMD_DELETE) begin
      while (n < NUM_SLOTS && !hit && slot_st_m[pos] != ST_EMPTY) begin
        if (slot_st_m[pos] == ST_USED && slot_key_m[pos] == key) hit = 1'b1;
        else begin
          pos = (pos + 1) % NUM_SLOTS;
          n++;
        end
      end
      if (hit) begin
        r.slot = pos[IDX_W-1:0];
        if (cmd == CMD_DELETE) begin
          slot_st_m[pos] = ST_DELETED;
          r.status = RES_DONE;
        end else begin
          r.status = RES_FOUND;
        end
      end
    end
    return r;
  endfunction

  // Queues one operation and tracks which keys the table will hold.
  task automatic queue_op(cmd_t cmd, logic [KEY_W-1:0] key);
    int idx;
    pending_ops.push_back({cmd, key});
    total_ops++;
    if (cmd != CMD_UNUSED) real_ops++;
    idx = -1;
    if (cmd == CMD_INSERT && live_keys.size() < NUM_SLOTS) begin
      live_keys.push_back(key);
    end else if (cmd == CMD_DELETE) begin
      foreach (live_keys[i])
        if (idx < 0 && live_keys[i] == key) idx = i;
      if (idx >= 0) live_keys.delete(idx);
    end
  endtask

  // Keys: half crowd the four home slots around the wrap point, a quarter are below 128, the rest are random.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    case ($urandom_range(0, 3))
      1: k = ($urandom_range(0, 7) << 4) | ((14 + $urandom_range(0, 3)) % 16);
      2: k = ($urandom_range(0, 7) << 4) | $urandom_range(0, 15);
      3: k = (k & 32'hFFFF_FFF0) | ((14 + $urandom_range(0, 3)) % 16);
      default: ;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_lookup_key();
    if (live_keys.size() > 0 && $urandom_range(0, 2) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return pick_key();
  endfunction

  task automatic oldest_op_drive(table_op_t op);
    in_command <= op.cmd;
    in_key_value <= op.key;
    start <= 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
      foreach (slot_st_m[i]) begin
        slot_st_m[i] = ST_EMPTY;
        slot_key_m[i] = '0;
      end
    end else begin
      if (start && !busy) begin
        pending_results.push_back(apply_op(in_command, in_key_value));
        accepted_cnt++;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        idle_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          oldest_op_drive(pending_ops.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding: status %0d slot %0d",
                                  out_status, out_slot_index));
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_status, oldest.status));
        if (out_slot_index !== oldest.slot)
          report_mismatch($sformatf("slot %0d, predicted %0d", out_slot_index, oldest.slot));
      end
    end
  end

  initial begin
    int keep;
    // empty table, unused command, extremes of the key, wrap and tombstones
    queue_op(CMD_SEARCH, 32'd5);
    queue_op(CMD_DELETE, 32'd5);
    queue_op(CMD_UNUSED, 32'd0);
    queue_op(CMD_INSERT, 32'd0);
    queue_op(CMD_INSERT, 32'hFFFF_FFFF);
    queue_op(CMD_INSERT, 32'd31);
    queue_op(CMD_INSERT, 32'd16);
    queue_op(CMD_SEARCH, 32'd16);
    queue_op(CMD_SEARCH, 32'd32);
    queue_op(CMD_DELETE, 32'd31);
    queue_op(CMD_SEARCH, 32'd16);
    queue_op(CMD_INSERT, 32'd47);
    queue_op(CMD_DELETE, 32'hFFFF_FFFF);
    queue_op(CMD_SEARCH, 32'd31);
    queue_op(CMD_DELETE, 32'd47);
    queue_op(CMD_SEARCH, 32'd47);
    queue_op(CMD_INSERT, 32'h8000_0003);
    queue_op(CMD_SEARCH, 32'h8000_0003);
    queue_op(CMD_SEARCH, 32'h7FFF_FFF3);
    queue_op(CMD_UNUSED, 32'hFFFF_FFFF);

    keep = real_ops;
    while (real_ops - keep < RANDOM_OPS) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          repeat (30) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6, 7: queue_op(CMD_INSERT, pick_key());
              8, 9, 10, 11, 12, 13:   queue_op(CMD_SEARCH, pick_lookup_key());
              19:                     queue_op(CMD_UNUSED, $urandom);
              default:                queue_op(CMD_DELETE, pick_lookup_key());
            endcase
          end
        end
        2: begin
          // fill up, overflow, then probe a full table
          while (live_keys.size() < NUM_SLOTS) queue_op(CMD_INSERT, pick_key());
          repeat ($urandom_range(1, 3)) queue_op(CMD_INSERT, pick_key());
          repeat (4) queue_op(CMD_SEARCH, pick_lookup_key());
        end
        3: begin
          // drain, leaving tombstones behind
          while (live_keys.size() > 0 && $urandom_range(0, 7) != 0) begin
            queue_op(CMD_DELETE, live_keys[$urandom_range(0, live_keys.size() - 1)]);
            if ($urandom_range(0, 1) == 0) queue_op(CMD_SEARCH, pick_key());
          end
        end
        default: begin
          repeat (10) queue_op(cmd_t'($urandom_range(0, 3)), $urandom);
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_ops || pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/htlp_pkg.sv
rtl/hash_table_linear_probe.sv
sim/hash_table_linear_probe_tb.sv
